### hdl/assert_macros.svh
// Assertion macros used by the checker file of the sorted key table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/skt_pkg.sv
// Package of the sorted key table: sizes, codes and shared types.
`default_nettype none

package skt_pkg;

   localparam int CAPACITY  = 64;
   localparam int KEY_WIDTH = 32;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   // Field widths on the channels
   localparam int OPCODE_W   = 2;
   localparam int KEY_IN_W   = 32;
   localparam int POSITION_W = 6;
   localparam int WHERE_W    = 6;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd2;

   // Broadcast to every cell of the chain
   typedef struct packed {
      logic                 ins;
      logic                 del;
      logic [IDX_W-1:0]     at;
      logic [KEY_WIDTH-1:0] key;
   } cell_cmd_type;

   // Outcome of the search sequencer
   typedef struct packed {
      logic             done;
      logic             found;
      logic [IDX_W-1:0] index;
   } srch_res_type;

endpackage

`default_nettype wire

### hdl/skt_if.sv
// Request and response channel interfaces of the sorted key table.
`default_nettype none

interface skt_req_if import skt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OPCODE_W-1:0]   opcode;
   logic [KEY_IN_W-1:0]   key;
   logic [POSITION_W-1:0] position;

   modport source (output valid, output opcode, output key, output position, input ready);
   modport sink (input valid, input opcode, input key, input position, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                hit;
   logic [WHERE_W-1:0]  where_index;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, output hit, output where_index, output status,
                   output entry_count, input ready);
   modport sink (input valid, input hit, input where_index, input status,
                 input entry_count, output ready);
endinterface

`default_nettype wire

### hdl/skt_cell.sv
// One cell of the key chain: holds a key, compares it, shifts with its neighbours.
`default_nettype none

module skt_cell import skt_pkg::*; (
   input  logic                 clock,
   input  cell_cmd_type         cmd,
   input  logic [IDX_W-1:0]     cell_index,
   input  logic [KEY_WIDTH-1:0] probe_key,
   input  logic [KEY_WIDTH-1:0] left_key,
   input  logic [KEY_WIDTH-1:0] right_key,
   output logic [KEY_WIDTH-1:0] key_out,
   output logic                 lt_flag,
   output logic                 eq_flag
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;

   always_comb begin
      key_in = key_ff;
      if (cmd.ins) begin
         if (cell_index == cmd.at) begin
            key_in = cmd.key;
         end else if (cell_index > cmd.at) begin
            key_in = left_key;
         end
      end else if (cmd.del && (cell_index >= cmd.at)) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out = key_ff;
   assign lt_flag = probe_key < key_ff;
   assign eq_flag = probe_key == key_ff;

endmodule

`default_nettype wire

### hdl/skt_search.sv
// Binary search sequencer: one probe of the cell flags per cycle.
`default_nettype none

module skt_search import skt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [CNT_W-1:0]    count,
   input  logic [CAPACITY-1:0] lt_vec,
   input  logic [CAPACITY-1:0] eq_vec,
   output srch_res_type        res
);

   typedef enum logic [1:0] {
      SR_IDLE = 2'b01,
      SR_RUN  = 2'b10
   } srch_state_type;

   srch_state_type   state_ff, state_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hip_ff, hip_in;   // upper bound plus one
   logic [CNT_W:0]   mid_sum;
   logic [IDX_W-1:0] mid;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hip_ff} - {{CNT_W{1'b0}}, 1'b1};
   assign mid     = mid_sum[IDX_W:1];

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hip_in    = hip_ff;
      res.done  = 1'b0;
      res.found = 1'b0;
      res.index = lo_ff[IDX_W-1:0];
      case (state_ff)
         SR_IDLE: begin
            if (start) begin
               lo_in    = '0;
               hip_in   = count;
               state_in = SR_RUN;
            end
         end
         SR_RUN: begin
            if (lo_ff >= hip_ff) begin
               // range exhausted: lower bound is the landing point
               res.done = 1'b1;
               state_in = SR_IDLE;
            end else if (eq_vec[mid]) begin
               res.done  = 1'b1;
               res.found = 1'b1;
               res.index = mid;
               state_in  = SR_IDLE;
            end else if (lt_vec[mid]) begin
               hip_in = CNT_W'(mid);
            end else begin
               lo_in = CNT_W'(mid) + CNT_W'(1);
            end
         end
         default: begin
            state_in = SR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hip_ff <= hip_in;
   end

endmodule

`default_nettype wire

### hdl/sorted_key_table_core.sv
// Delete, clear, full insert and empty-table requests pass from the execute state straight to the
// respond state. Insert and find on a non-empty table go through the search state between them,
// where the sequencer makes a single probe per cycle until a probe hits or the range is exhausted.
// Throughput: one request at a time; the next is taken the cycle after the response registers.
// Reset clears the count, the control state and the response valid; key cells keep contents.
`default_nettype none

module sorted_key_table_core import skt_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   skt_req_if.sink   req_chan,
   skt_rsp_if.source rsp_chan
);

   // Top-level sequencer, one-hot
   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_EXEC    = 4'b0010,
      S_SEARCH  = 4'b0100,
      S_RESPOND = 4'b1000
   } core_state_type;

   core_state_type        state_ff, state_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Held request
   logic [OPCODE_W-1:0]   op_ff;
   logic [KEY_WIDTH-1:0]  key_ff;
   logic [IDX_W-1:0]      pos_ff;

   // Pending result, waiting for the response register
   logic                  res_hit_ff, res_hit_in;
   logic [IDX_W-1:0]      res_where_ff, res_where_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;

   // Response register
   logic                  rsp_hit_ff;
   logic [WHERE_W-1:0]    rsp_where_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic                  req_accept;
   logic                  rsp_load;
   logic                  srch_start;
   srch_res_type          srch_res;
   cell_cmd_type          cmd;

   logic [KEY_WIDTH-1:0]  cell_keys  [CAPACITY];
   logic [KEY_WIDTH-1:0]  left_keys  [CAPACITY];
   logic [KEY_WIDTH-1:0]  right_keys [CAPACITY];
   logic [CAPACITY-1:0]   lt_vec;
   logic [CAPACITY-1:0]   eq_vec;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Sequencer: decide the operation, run the search, apply the shift, respond
   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      res_hit_in    = res_hit_ff;
      res_where_in  = res_where_ff;
      res_status_in = res_status_ff;
      srch_start    = 1'b0;
      rsp_load      = 1'b0;
      cmd.ins       = 1'b0;
      cmd.del       = 1'b0;
      cmd.at        = '0;
      cmd.key       = key_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_hit_in    = 1'b0;
            res_where_in  = '0;
            res_status_in = ST_OK;
            state_in      = S_RESPOND;
            case (op_ff)
               OP_INSERT: begin
                  if (occ_ff >= CNT_W'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                  end else if (occ_ff == '0) begin
                     // empty table: place at the head without a search
                     cmd.ins = 1'b1;
                     occ_in  = occ_ff + CNT_W'(1);
                  end else begin
                     srch_start = 1'b1;
                     state_in   = S_SEARCH;
                  end
               end
               OP_FIND: begin
                  if (occ_ff != '0) begin
                     srch_start = 1'b1;
                     state_in   = S_SEARCH;
                  end
               end
               OP_DELETE: begin
                  if (CNT_W'(pos_ff) >= occ_ff) begin
                     res_status_in = ST_BAD_POS;
                  end else begin
                     cmd.del = 1'b1;
                     cmd.at  = pos_ff;
                     occ_in  = occ_ff - CNT_W'(1);
                  end
               end
               OP_CLEAR: begin
                  occ_in = '0;
               end
               default: begin
                  state_in = S_RESPOND;
               end
            endcase
         end
         S_SEARCH: begin
            if (srch_res.done) begin
               state_in = S_RESPOND;
               if (op_ff == OP_INSERT) begin
                  // shift later entries up and drop the key in at the landing point
                  cmd.ins      = 1'b1;
                  cmd.at       = srch_res.index;
                  occ_in       = occ_ff + CNT_W'(1);
                  res_where_in = srch_res.index;
               end else begin
                  res_hit_in   = srch_res.found;
                  res_where_in = srch_res.found ? srch_res.index : '0;
               end
            end
         end
         S_RESPOND: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_chan.opcode;
         key_ff <= KEY_WIDTH'(req_chan.key);
         pos_ff <= IDX_W'(req_chan.position);
      end
      res_hit_ff    <= res_hit_in;
      res_where_ff  <= res_where_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_hit_ff    <= res_hit_ff;
         rsp_where_ff  <= WHERE_W'(res_where_ff);
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= COUNT_W'(occ_ff);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.where_index = rsp_where_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   // Chain of key cells; the ends see no neighbour on their outer side
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_keys[g] = '0;
      end else begin : g_left
         assign left_keys[g] = cell_keys[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_keys[g] = '0;
      end else begin : g_right
         assign right_keys[g] = cell_keys[g+1];
      end

      skt_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (IDX_W'(g)),
         .probe_key  (key_ff),
         .left_key   (left_keys[g]),
         .right_key  (right_keys[g]),
         .key_out    (cell_keys[g]),
         .lt_flag    (lt_vec[g]),
         .eq_flag    (eq_vec[g])
      );
   end

   // Search sequencer probes the compare flags of the cells
   skt_search u_search (
      .clock  (clock),
      .reset  (reset),
      .start  (srch_start),
      .count  (occ_ff),
      .lt_vec (lt_vec),
      .eq_vec (eq_vec),
      .res    (srch_res)
   );

endmodule

`default_nettype wire

### hdl/skt_checker.sv
// Port-level checker of the sorted key table and its bind.
`default_nettype none

`include "assert_macros.svh"

module skt_checker import skt_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic                rsp_hit,
   input wire logic [WHERE_W-1:0]  rsp_where_index,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [COUNT_W-1:0]  rsp_entry_count
);

   `ASSERT_IMPLIES(a_count_bound, clock, reset, rsp_valid, rsp_entry_count <= COUNT_W'(CAPACITY), "entry count beyond capacity")

   `ASSERT_IMPLIES(a_hit_ok, clock, reset, rsp_valid && rsp_hit, rsp_status == ST_OK, "hit with error status")

   `ASSERT_IMPLIES(a_full_count, clock, reset, rsp_valid && (rsp_status == ST_FULL), (rsp_entry_count == COUNT_W'(CAPACITY)) && (rsp_where_index == '0), "full status on a table not full")

   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_entry_count) && $stable(rsp_status), "stalled response changed")

endmodule

bind sorted_key_table_core skt_checker u_skt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_hit         (rsp_chan.hit),
   .rsp_where_index (rsp_chan.where_index),
   .rsp_status      (rsp_chan.status),
   .rsp_entry_count (rsp_chan.entry_count)
);

`default_nettype wire
